// ----- hdl/bba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the buddy block allocator.
package bba_pkg;

  // Field widths of the words on the channels.
  localparam int ADDR_W = 24;
  localparam int SIZE_W = 25;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOMEM   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_POOL    = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] size_bytes;
    logic              size_given;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] granted_address;
  } out_word_t;

  // A finished result offered by the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

// ----- hdl/bba_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and a registered read port.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bba_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the allocator: walks the free lists held in the node memories,
// splits and merges blocks and keeps the list heads, tails and pool bits.
module bba_seq
  import bba_pkg::*;
#(
  parameter int LEVEL_COUNT     = 24,
  parameter int NODE_POOL_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_word,
  output logic     busy,
  output res_t     res,
  input  logic     res_take
);

  localparam int IW  = $clog2(NODE_POOL_DEPTH);
  localparam int NW  = $clog2(NODE_POOL_DEPTH + 1);
  localparam int LVW = $clog2(LEVEL_COUNT + 1);
  localparam int LIW = $clog2(LEVEL_COUNT);
  localparam int CW  = (NW > LVW) ? NW : LVW;
  localparam logic [NW-1:0]  NO_NODE = NW'(NODE_POOL_DEPTH);
  localparam logic [LVW-1:0] LV_TOP  = LVW'(LEVEL_COUNT);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LVW-1:0]    level;
    logic              is_free;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADD_TAKE, S_ADD_LINK, S_AL_SRCH, S_AL_POP, S_AL_SPLIT,
    S_FR_SCAN, S_FR_PUSH, S_FR_MCHK, S_FF_RD, S_FF_EV, S_UL_RD, S_UL_EV,
    S_UL_END, S_DONE
  } state_t;

  // Level of a size: least k with size <= 2^k, capped at the level count.
  function automatic logic [LVW-1:0] level_of(input logic [SIZE_W-1:0] size);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if ({1'b0, size} > ((SIZE_W + 1)'(1) << i)) begin
        k = 6'(i + 1);
      end
    end
    if (k >= 6'(LEVEL_COUNT)) begin
      return LV_TOP;
    end
    return LVW'(k);
  endfunction

  state_t               state_r;
  logic [1:0]           op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [ADDR_W-1:0]    target_r;
  logic [ADDR_W-1:0]    base_r;
  logic [LVW-1:0]       size_lv_r;
  logic                 given_r;
  logic [LVW-1:0]       lv_r;
  logic [LVW-1:0]       j_r;
  logic [LVW-1:0]       k_r;
  logic [IW-1:0]        n_r;
  logic [IW-1:0]        b_r;
  logic [IW-1:0]        x_r;
  logic [NW-1:0]        cur_r;
  logic [NW-1:0]        prev_r;
  logic [NW-1:0]        idx_r;
  logic [IW-1:0]        idx_d_r;
  logic                 pipe_v_r;
  logic                 found_r;
  logic [IW-1:0]        best_r;
  logic [LVW-1:0]       best_lv_r;
  logic                 second_r;
  logic [NW-1:0]        used_r;
  logic [NODE_POOL_DEPTH-1:0] in_use_r;
  logic [NW-1:0]        head_r [LEVEL_COUNT];
  logic [NW-1:0]        tail_r [LEVEL_COUNT];
  out_word_t            res_r;

  // Memory ports.
  logic          d_we;
  logic [IW-1:0] d_waddr;
  node_t         d_wdata;
  logic          l_we;
  logic [IW-1:0] l_waddr;
  logic [NW-1:0] l_wdata;
  logic [IW-1:0] rd_addr;
  logic [$bits(node_t)-1:0] d_rdata;
  logic [NW-1:0] l_rdata;
  node_t         d_rd;

  // Helpers derived from the current registers.
  logic [LIW-1:0]    lvi;
  logic [LIW-1:0]    ji;
  logic [LVW-1:0]    km1;
  logic [LIW-1:0]    km1i;
  logic [NW-1:0]     head_lv;
  logic [NW-1:0]     tail_lv;
  logic [ADDR_W-1:0] bit_w;
  logic              idx_hit;
  logic              sc_match;
  logic [NW-1:0]     unused;
  logic [LVW-1:0]    need;

  assign d_rd    = node_t'(d_rdata);
  assign lvi     = lv_r[LIW-1:0];
  assign ji      = j_r[LIW-1:0];
  assign km1     = k_r - LVW'(1);
  assign km1i    = km1[LIW-1:0];
  assign head_lv = head_r[lvi];
  assign tail_lv = tail_r[lvi];
  assign bit_w   = ADDR_W'(1) << lv_r;
  assign idx_hit = (idx_r < NO_NODE) && !in_use_r[idx_r[IW-1:0]];
  assign unused  = NO_NODE - used_r;
  assign need    = j_r - lv_r;
  assign busy    = (state_r != S_IDLE);
  assign res     = '{valid: (state_r == S_DONE), word: res_r};

  // Best allocated match so far in the free scan: lowest level, then lowest node.
  assign sc_match = pipe_v_r && in_use_r[idx_d_r] && !d_rd.is_free &&
                    (d_rd.addr == addr_r) &&
                    (!given_r || (d_rd.level == size_lv_r)) &&
                    (!found_r || (d_rd.level < best_lv_r));

  bba_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_POOL_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (rd_addr),
    .rdata (d_rdata)
  );

  bba_ram #(.WIDTH(NW), .DEPTH(NODE_POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (rd_addr),
    .rdata (l_rdata)
  );

  // Memory accesses of each step.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    rd_addr = '0;
    unique case (state_r)
      S_ADD_TAKE: begin
        if (idx_hit) begin
          d_we    = 1'b1;
          d_waddr = idx_r[IW-1:0];
          d_wdata = '{addr: addr_r, level: lv_r, is_free: 1'b1};
          l_we    = 1'b1;
          l_waddr = idx_r[IW-1:0];
          l_wdata = NO_NODE;
        end
      end
      S_ADD_LINK: begin
        if (head_lv != NO_NODE) begin
          l_we    = 1'b1;
          l_waddr = tail_lv[IW-1:0];
          l_wdata = NW'(n_r);
        end
      end
      S_AL_SRCH: begin
        if (j_r < LV_TOP) begin
          rd_addr = head_r[ji][IW-1:0];
        end
      end
      S_AL_SPLIT: begin
        if (k_r == lv_r) begin
          d_we    = 1'b1;
          d_waddr = n_r;
          d_wdata = '{addr: base_r, level: lv_r, is_free: 1'b0};
        end else if (idx_hit) begin
          d_we    = 1'b1;
          d_waddr = idx_r[IW-1:0];
          d_wdata = '{addr: base_r + (ADDR_W'(1) << km1), level: km1, is_free: 1'b1};
          l_we    = 1'b1;
          l_waddr = idx_r[IW-1:0];
          l_wdata = head_r[km1i];
        end
      end
      S_FR_SCAN: begin
        rd_addr = idx_r[IW-1:0];
        if ((idx_r == NO_NODE) && !pipe_v_r && found_r) begin
          d_we    = 1'b1;
          d_waddr = best_r;
          d_wdata = '{addr: addr_r, level: best_lv_r, is_free: 1'b1};
        end
      end
      S_FR_PUSH: begin
        l_we    = 1'b1;
        l_waddr = n_r;
        l_wdata = head_lv;
      end
      S_FF_RD, S_UL_RD: begin
        rd_addr = cur_r[IW-1:0];
      end
      S_UL_EV: begin
        if ((cur_r == NW'(x_r)) && (prev_r != NO_NODE)) begin
          l_we    = 1'b1;
          l_waddr = prev_r[IW-1:0];
          l_wdata = l_rdata;
        end
      end
      S_UL_END: begin
        if (second_r) begin
          d_we    = 1'b1;
          d_waddr = n_r;
          d_wdata = '{addr: addr_r & ~bit_w, level: lv_r + LVW'(1), is_free: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, list heads and tails, pool bits and result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_use_r <= '0;
      used_r   <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        head_r[i] <= NO_NODE;
        tail_r[i] <= NO_NODE;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_word.opcode;
            addr_r    <= in_word.block_address;
            size_lv_r <= level_of(in_word.size_bytes);
            given_r   <= in_word.size_given;
            state_r   <= S_DISP;
          end
        end
        S_DISP: begin
          pipe_v_r  <= 1'b0;
          found_r   <= 1'b0;
          idx_r     <= '0;
          second_r  <= 1'b0;
          res_r.granted_address <= '0;
          lv_r      <= size_lv_r;
          j_r       <= size_lv_r;
          case (op_r)
            OP_ADD: begin
              if (addr_r == '0) begin
                res_r.status <= ST_NULL;
                state_r      <= S_DONE;
              end else if (size_lv_r >= LV_TOP) begin
                res_r.status <= ST_NOMEM;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_ADD_TAKE;
              end
            end
            OP_ALLOC: begin
              if (size_lv_r >= LV_TOP) begin
                res_r.status <= ST_NOMEM;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_AL_SRCH;
              end
            end
            OP_FREE: begin
              if (addr_r == '0) begin
                res_r.status <= ST_NULL;
                state_r      <= S_DONE;
              end else if (given_r && (size_lv_r >= LV_TOP)) begin
                res_r.status <= ST_INVALID;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_FR_SCAN;
              end
            end
            default: begin
              res_r.status <= ST_OK;
              state_r      <= S_DONE;
            end
          endcase
        end
        // Add: take the lowest unused node, then append it to its list.
        S_ADD_TAKE: begin
          if (idx_r == NO_NODE) begin
            res_r.status <= ST_POOL;
            state_r      <= S_DONE;
          end else if (idx_hit) begin
            n_r                        <= idx_r[IW-1:0];
            in_use_r[idx_r[IW-1:0]]    <= 1'b1;
            used_r                     <= used_r + NW'(1);
            state_r                    <= S_ADD_LINK;
          end else begin
            idx_r <= idx_r + NW'(1);
          end
        end
        S_ADD_LINK: begin
          if (head_lv == NO_NODE) begin
            head_r[lvi] <= NW'(n_r);
          end
          tail_r[lvi]  <= NW'(n_r);
          res_r.status <= ST_OK;
          state_r      <= S_DONE;
        end
        // Allocate: find the nearest non-empty level at or above the request.
        S_AL_SRCH: begin
          if (j_r >= LV_TOP) begin
            res_r.status <= ST_NOMEM;
            state_r      <= S_DONE;
          end else if (head_r[ji] != NO_NODE) begin
            if (CW'(unused) < CW'(need)) begin
              res_r.status <= ST_POOL;
              state_r      <= S_DONE;
            end else begin
              n_r     <= head_r[ji][IW-1:0];
              state_r <= S_AL_POP;
            end
          end else begin
            j_r <= j_r + LVW'(1);
          end
        end
        S_AL_POP: begin
          base_r     <= d_rd.addr;
          head_r[ji] <= l_rdata;
          if (tail_r[ji] == NW'(n_r)) begin
            tail_r[ji] <= NO_NODE;
          end
          k_r     <= j_r;
          idx_r   <= '0;
          state_r <= S_AL_SPLIT;
        end
        // One split per unused node found: the upper half joins the list front.
        S_AL_SPLIT: begin
          if (k_r == lv_r) begin
            if (base_r == '0) begin
              res_r.status <= ST_NOMEM;
            end else begin
              res_r.status          <= ST_OK;
              res_r.granted_address <= base_r;
            end
            state_r <= S_DONE;
          end else if (idx_hit) begin
            in_use_r[idx_r[IW-1:0]] <= 1'b1;
            used_r                  <= used_r + NW'(1);
            if (head_r[km1i] == NO_NODE) begin
              tail_r[km1i] <= idx_r;
            end
            head_r[km1i] <= idx_r;
            k_r          <= km1;
            idx_r        <= idx_r + NW'(1);
          end else begin
            idx_r <= idx_r + NW'(1);
          end
        end
        // Free: pipelined scan of all nodes for the allocated block.
        S_FR_SCAN: begin
          if (sc_match) begin
            best_r    <= idx_d_r;
            best_lv_r <= d_rd.level;
            found_r   <= 1'b1;
          end
          if (idx_r != NO_NODE) begin
            pipe_v_r <= 1'b1;
            idx_d_r  <= idx_r[IW-1:0];
            idx_r    <= idx_r + NW'(1);
          end else begin
            pipe_v_r <= 1'b0;
            if (!pipe_v_r) begin
              if (found_r) begin
                n_r     <= best_r;
                lv_r    <= best_lv_r;
                state_r <= S_FR_PUSH;
              end else begin
                res_r.status <= ST_INVALID;
                state_r      <= S_DONE;
              end
            end
          end
        end
        S_FR_PUSH: begin
          if (head_lv == NO_NODE) begin
            tail_r[lvi] <= NW'(n_r);
          end
          head_r[lvi] <= NW'(n_r);
          state_r     <= S_FR_MCHK;
        end
        S_FR_MCHK: begin
          if ((lv_r + LVW'(1)) >= LV_TOP) begin
            res_r.status <= ST_OK;
            state_r      <= S_DONE;
          end else begin
            target_r <= addr_r ^ bit_w;
            cur_r    <= head_lv;
            state_r  <= S_FF_RD;
          end
        end
        // Walk the level's list for the buddy.
        S_FF_RD: begin
          if (cur_r == NO_NODE) begin
            res_r.status <= ST_OK;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_FF_EV;
          end
        end
        S_FF_EV: begin
          if (d_rd.addr == target_r) begin
            b_r      <= cur_r[IW-1:0];
            x_r      <= cur_r[IW-1:0];
            cur_r    <= head_lv;
            prev_r   <= NO_NODE;
            second_r <= 1'b0;
            state_r  <= S_UL_RD;
          end else begin
            cur_r   <= l_rdata;
            state_r <= S_FF_RD;
          end
        end
        // Unlink the buddy, then the freed block, from the level's list.
        S_UL_RD: begin
          state_r <= (cur_r == NO_NODE) ? S_UL_END : S_UL_EV;
        end
        S_UL_EV: begin
          if (cur_r == NW'(x_r)) begin
            if (prev_r == NO_NODE) begin
              head_r[lvi] <= l_rdata;
            end
            if (tail_lv == cur_r) begin
              tail_r[lvi] <= prev_r;
            end
            state_r <= S_UL_END;
          end else begin
            prev_r  <= cur_r;
            cur_r   <= l_rdata;
            state_r <= S_UL_RD;
          end
        end
        S_UL_END: begin
          if (!second_r) begin
            second_r <= 1'b1;
            x_r      <= n_r;
            cur_r    <= head_lv;
            prev_r   <= NO_NODE;
            state_r  <= S_UL_RD;
          end else begin
            in_use_r[b_r] <= 1'b0;
            used_r        <= used_r - NW'(1);
            addr_r        <= addr_r & ~bit_w;
            lv_r          <= lv_r + LVW'(1);
            second_r      <= 1'b0;
            state_r       <= S_FR_PUSH;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/buddy_block_allocator_core.sv -----
`timescale 1ns / 1ps
// Power-of-two buddy block allocator.
// The input channel (in_valid, in_stall, in_word) carries one request word:
// add a free chunk, allocate a block or free a block. The result channel
// (out_valid, out_stall, out_word) returns exactly one word per request with
// a status and, for a successful allocate, the granted address.
// Requests are handled one at a time. An add's time is set by the scan for the
// lowest unused node. An allocate runs a level search plus the node scan
// shared by its splits. A free scans the node memory, then per merge step
// walks the level's free list across the buddy search and two unlinks.
// The result is registered; the next request is taken as soon as the result
// has moved into the output register, even while the receiver stalls it.
// A stalled result holds until taken, and a further result waits inside.
// Reset empties every free list and the node pool at once; no clearing pass.
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int LEVEL_COUNT     = 24,
  parameter int NODE_POOL_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  res_t      res;
  logic      res_take;
  logic      out_valid_r;
  out_word_t out_word_r;

  bba_seq #(
    .LEVEL_COUNT     (LEVEL_COUNT),
    .NODE_POOL_DEPTH (NODE_POOL_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .busy     (in_stall),
    .res      (res),
    .res_take (res_take)
  );

  // The output register loads when empty or when its word is being taken.
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hdl/bba_chk.sv -----
`timescale 1ns / 1ps
// Port-level checks of the allocator.
module bba_chk
  import bba_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Only a successful allocate carries an address.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |-> out_word.granted_address == '0)
    else $error("address on a failed request");

  // Status is one of the defined codes.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == ST_OK) || (out_word.status == ST_NOMEM) ||
                  (out_word.status == ST_INVALID) || (out_word.status == ST_NULL) ||
                  (out_word.status == ST_POOL))
    else $error("undefined status code");

  // After a request is taken the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken at once");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind buddy_block_allocator_core bba_chk u_bba_chk (.*);
